FILE: hw/rtl/tlcc_pkg.sv
// Package for the traffic lamp command controller.
// Holds the shared types, command codes, register indexes and helper functions.
// No dependencies.
package tlcc_pkg;

    // Elapsed-time counter width
    localparam int TIMER_BITS = 16;
    // Width of the delay registers
    localparam int CFG_W      = 16;
    // Common compare width for counter against delay
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    localparam int IDX_W      = 8;
    localparam logic [IDX_W-1:0] REG_CYCLE_DELAY = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_BLINK_DELAY = IDX_W'(1);

    localparam logic [CFG_W-1:0] CYCLE_DELAY_RST = CFG_W'(100);
    localparam logic [CFG_W-1:0] BLINK_DELAY_RST = CFG_W'(500);

    // Upper-case command characters; lower case folds onto them
    localparam logic [7:0] CHR_R    = 8'h52;
    localparam logic [7:0] CHR_Y    = 8'h59;
    localparam logic [7:0] CHR_G    = 8'h47;
    localparam logic [7:0] CHR_O    = 8'h4F;
    localparam logic [7:0] CHR_D    = 8'h44;
    localparam logic [7:0] CHR_B    = 8'h42;
    localparam logic [7:0] CASE_MSK = 8'hDF;

    typedef enum logic [1:0] {
        LAMP_OFF    = 2'd0,
        LAMP_RED    = 2'd1,
        LAMP_YELLOW = 2'd2,
        LAMP_GREEN  = 2'd3
    } t_lamp;

    typedef struct packed {
        t_lamp                 lamp;
        logic                  cycle_on;
        logic [1:0]            phase;
        logic [TIMER_BITS-1:0] cycle_el;
        logic                  blink_active;
        logic [TIMER_BITS-1:0] blink_el;
        logic                  led;
    } t_state;

    typedef struct packed {
        logic red_on;
        logic yellow_on;
        logic green_on;
        logic board_led;
        logic bad_command;
    } t_result;

    // Saturating increment of an elapsed counter
    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Lamp shown in each cycle phase: red, yellow, green, yellow
    function automatic t_lamp phase_lamp(input logic [1:0] ph);
        t_lamp l;
        case (ph)
            2'd0:    l = LAMP_RED;
            2'd2:    l = LAMP_GREEN;
            default: l = LAMP_YELLOW;
        endcase
        return l;
    endfunction

endpackage

FILE: hw/rtl/tlcc_step.sv
// Next-state and result logic for one tick or command transaction.
// Depends on tlcc_pkg.
module tlcc_step (
    input  tlcc_pkg::t_state              i_state,
    input  logic                          i_func,
    input  logic [7:0]                    i_cmd_byte,
    input  logic [tlcc_pkg::CFG_W-1:0]    i_cycle_delay,
    input  logic [tlcc_pkg::CFG_W-1:0]    i_blink_delay,
    output tlcc_pkg::t_state              o_state,
    output tlcc_pkg::t_result             o_result
);

    tlcc_pkg::t_state s;
    logic             bad;
    logic             started;
    logic [7:0]       upper;

    always_comb begin
        s       = i_state;
        bad     = 1'b0;
        started = 1'b0;
        upper   = i_cmd_byte & tlcc_pkg::CASE_MSK;

        // Command decode, or tick advance of the running counters
        if (i_func) begin
            unique case (upper)
                tlcc_pkg::CHR_R: begin
                    s.cycle_on = 1'b0;
                    s.lamp     = tlcc_pkg::LAMP_RED;
                end
                tlcc_pkg::CHR_Y: begin
                    s.cycle_on = 1'b0;
                    s.lamp     = tlcc_pkg::LAMP_YELLOW;
                end
                tlcc_pkg::CHR_G: begin
                    s.cycle_on = 1'b0;
                    s.lamp     = tlcc_pkg::LAMP_GREEN;
                end
                tlcc_pkg::CHR_O: begin
                    s.cycle_on = 1'b0;
                    s.lamp     = tlcc_pkg::LAMP_OFF;
                end
                tlcc_pkg::CHR_D: begin
                    s.cycle_on = 1'b1;
                    s.phase    = 2'd0;
                    s.lamp     = tlcc_pkg::phase_lamp(2'd0);
                    s.cycle_el = '0;
                    started    = 1'b1;
                end
                tlcc_pkg::CHR_B: begin
                    s.blink_active = 1'b1;
                    s.blink_el     = '0;
                end
                default: bad = 1'b1;
            endcase
        end else begin
            if (s.cycle_on) s.cycle_el = tlcc_pkg::sat_inc(s.cycle_el);
            if (s.blink_active) s.blink_el = tlcc_pkg::sat_inc(s.blink_el);
        end

        // Cycle step once the delay is reached (not on the starting command)
        if (s.cycle_on && !started &&
            (tlcc_pkg::CMP_W'(s.cycle_el) >= tlcc_pkg::CMP_W'(i_cycle_delay))) begin
            s.phase    = s.phase + 2'd1;
            s.lamp     = tlcc_pkg::phase_lamp(s.phase);
            s.cycle_el = '0;
        end

        // Blink: LED low until the delay is exceeded, then high and done
        if (s.blink_active) begin
            if (tlcc_pkg::CMP_W'(s.blink_el) > tlcc_pkg::CMP_W'(i_blink_delay)) begin
                s.led          = 1'b1;
                s.blink_active = 1'b0;
            end else begin
                s.led = 1'b0;
            end
        end
    end

    assign o_state              = s;
    assign o_result.red_on      = (s.lamp == tlcc_pkg::LAMP_RED);
    assign o_result.yellow_on   = (s.lamp == tlcc_pkg::LAMP_YELLOW);
    assign o_result.green_on    = (s.lamp == tlcc_pkg::LAMP_GREEN);
    assign o_result.board_led   = s.led;
    assign o_result.bad_command = bad;

endmodule

FILE: hw/rtl/traffic_lamp_command_controller_core.sv
// Traffic lamp command controller, top level: handshakes, state and config registers.
// Depends on tlcc_pkg and tlcc_step.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per tick or
//   received command byte: i_in_func = 0 for a 1 ms tick, 1 for a command in
//   i_in_cmd_byte (R Y G O D B, either case).
//   Output channel (o_out_valid / i_out_ready) returns one result per input
//   transaction: lamp levels, board LED level and the bad-command flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes cycle_delay (index 0) and
//   blink_delay (index 1); other indexes are ignored. Always ready.
// Timing:
//   The result is registered at the edge that accepts the input. Throughput
//   is one transaction per cycle while the result register is empty or drained,
//   set by the single next-state pass between the state and result registers.
// Reset:
//   Synchronous, active low. Lamp off, LED low, no cycle or blink running,
//   delays back to 100 and 500, output register empty.
// Stall:
//   While a result waits and i_out_ready is low, o_in_ready is low; input is
//   taken again in the cycle the result is taken.
module traffic_lamp_command_controller_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input transactions
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_in_func,
    input  logic [7:0]                    i_in_cmd_byte,
    // result transactions
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_red_on,
    output logic                          o_yellow_on,
    output logic                          o_green_on,
    output logic                          o_board_led,
    output logic                          o_bad_command,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tlcc_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [tlcc_pkg::CFG_W-1:0]    i_cfg_data
);

    tlcc_pkg::t_state            r_state;
    tlcc_pkg::t_state            n_state;
    tlcc_pkg::t_result           n_result;
    tlcc_pkg::t_result           r_result;
    logic                        r_out_valid;
    logic [tlcc_pkg::CFG_W-1:0]  r_cycle_delay;
    logic [tlcc_pkg::CFG_W-1:0]  r_blink_delay;
    logic                        in_fire;

    // Accept when the result register is empty or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    tlcc_step u_step (
        .i_state       (r_state),
        .i_func        (i_in_func),
        .i_cmd_byte    (i_in_cmd_byte),
        .i_cycle_delay (r_cycle_delay),
        .i_blink_delay (r_blink_delay),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.lamp         <= tlcc_pkg::LAMP_OFF;
            r_state.cycle_on     <= 1'b0;
            r_state.phase        <= 2'd0;
            r_state.cycle_el     <= '0;
            r_state.blink_active <= 1'b0;
            r_state.blink_el     <= '0;
            r_state.led          <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Delay registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_delay <= tlcc_pkg::CYCLE_DELAY_RST;
            r_blink_delay <= tlcc_pkg::BLINK_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tlcc_pkg::REG_CYCLE_DELAY: r_cycle_delay <= i_cfg_data;
                tlcc_pkg::REG_BLINK_DELAY: r_blink_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_on      = r_result.red_on;
    assign o_yellow_on   = r_result.yellow_on;
    assign o_green_on    = r_result.green_on;
    assign o_board_led   = r_result.board_led;
    assign o_bad_command = r_result.bad_command;

    // Checks
    a_lamp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_red_on, o_yellow_on, o_green_on}))
        else $error("more than one lamp driven");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    a_cycle_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cycle_on |-> (r_state.lamp != tlcc_pkg::LAMP_OFF))
        else $error("cycle mode running with lamp off");

endmodule
